// ----- src/assert_macros.svh -----
// Assertion macros shared by the stereo peak limiter RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define SPL_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Expression must never be true at a rising clock edge outside reset.
`define SPL_ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

// ----- src/spl_pkg.sv -----
// Package for the stereo peak limiter: default widths, register map and reset values.
// Used by spl_divider and stereo_peak_limiter; depends on nothing.
`default_nettype none

package spl_pkg;

   localparam int SAMPLE_BITS_DEFAULT        = 24;
   localparam int GAIN_FRACTION_BITS_DEFAULT = 24;
   localparam int MASTER_GAIN_BITS           = 17;

   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [1:0] REG_CEILING = 2'd0;
   localparam logic [1:0] REG_ATTACK  = 2'd1;
   localparam logic [1:0] REG_RELEASE = 2'd2;

   localparam logic [63:0] CEILING_RESET = 64'd8136950;
   localparam logic [63:0] ATTACK_RESET  = 64'd6710886;
   localparam logic [63:0] RELEASE_RESET = 64'd13422;

endpackage

`default_nettype wire

// ----- src/spl_divider.sv -----
// Restoring divider for the limiter target gain, one quotient bit per cycle.
// Computes (numerator << GAIN_FRACTION_BITS) / divisor for numerator < divisor; uses spl_pkg.
`default_nettype none

module spl_divider #(
   parameter int SAMPLE_BITS        = spl_pkg::SAMPLE_BITS_DEFAULT,
   parameter int GAIN_FRACTION_BITS = spl_pkg::GAIN_FRACTION_BITS_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [SAMPLE_BITS-2:0]        numerator,
   input  wire logic [SAMPLE_BITS+2:0]        divisor,
   output logic                               done,
   output logic [GAIN_FRACTION_BITS-1:0]      quotient
);

   localparam int S  = SAMPLE_BITS;
   localparam int G  = GAIN_FRACTION_BITS;
   localparam int CW = $clog2(G + 1);

   logic [S+2:0]  rem_ff;
   logic [S+2:0]  rem_in;
   logic [S+2:0]  div_ff;
   logic [G-1:0]  quot_ff;
   logic [CW-1:0] count_ff;
   logic          busy_ff;
   logic          done_ff;
   logic [S+3:0]  rem_shift;
   logic [S+3:0]  rem_diff;
   logic          fits;

   assign rem_shift = {rem_ff, 1'b0};
   assign rem_diff  = rem_shift - {1'b0, div_ff};
   assign fits      = rem_shift >= {1'b0, div_ff};
   assign rem_in    = fits ? rem_diff[S+2:0] : rem_shift[S+2:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff  <= 1'b1;
            count_ff <= CW'(G);
         end else if (busy_ff) begin
            count_ff <= count_ff - 1'b1;
            if (count_ff == CW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= (S+3)'(numerator);
         div_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff  <= rem_in;
         quot_ff <= {quot_ff[G-2:0], fits};
      end
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

`default_nettype wire

// ----- src/stereo_peak_limiter.sv -----
// Stereo peak limiter top level: stream ports, APB-style register port and sequencer.
// Uses spl_pkg, spl_divider and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

// The block takes one stereo frame per transfer, applies the master gain, derives a target
// gain from the ceiling, smooths the kept limiter gain with the attack or release coefficient
// and returns the limited, clipped frame. All products go through one shared multiplier under
// a small sequencer, five uses per frame. A frame passes through the states MUL_L, MUL_R, PEAK,
// STEP, UPDATE, OUT_L, OUT_R and EMIT; when the peak exceeds the ceiling, a DIV state between
// PEAK and STEP waits for the one-bit-per-cycle divider that computes the target gain.
// The input is not ready while a frame is in work; a finished result waits in an output
// register, so the next frame can be taken before the previous result is read.
module stereo_peak_limiter #(
   parameter int SAMPLE_BITS        = spl_pkg::SAMPLE_BITS_DEFAULT,
   parameter int GAIN_FRACTION_BITS = spl_pkg::GAIN_FRACTION_BITS_DEFAULT
) (
   input  wire logic clock,
   input  wire logic reset,
   // Fields from bit 0: left_in, right_in, master_gain, zero padding.
   input  wire logic [((2*SAMPLE_BITS+spl_pkg::MASTER_GAIN_BITS+7)/8)*8-1:0] req_tdata,
   input  wire logic req_tvalid,
   input  wire logic req_tlast,
   output logic      req_tready,
   // Fields from bit 0: left_out, right_out, zero padding.
   output logic [((2*SAMPLE_BITS+7)/8)*8-1:0] rsp_tdata,
   output logic      rsp_tvalid,
   output logic      rsp_tlast,
   input  wire logic rsp_tready,
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [spl_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  wire logic [spl_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic [spl_pkg::CSR_DATA_BITS-1:0]        csr_prdata,
   output logic                                     csr_pready
);

   localparam int S   = SAMPLE_BITS;
   localparam int G   = GAIN_FRACTION_BITS;
   localparam int MGB = spl_pkg::MASTER_GAIN_BITS;
   localparam int AW  = (S > G + 1) ? S : G + 1;
   localparam int BW  = G + 1;
   localparam int PW  = AW + BW;
   localparam int RSP_BITS = ((2*S+7)/8)*8;

   localparam logic [G:0]    GAIN_ONE   = {1'b1, {G{1'b0}}};
   localparam logic [PW-1:0] BIAS_Q16   = {{(PW-16){1'b0}}, 1'b1, {15{1'b0}}};
   localparam logic [PW-1:0] BIAS_STEP  = {{(PW-G){1'b0}}, {G{1'b1}}};
   localparam logic [PW-1:0] BIAS_OUT   = {{(PW-G+3){1'b0}}, 1'b1, {(G-4){1'b0}}};
   localparam logic [S+3:0]  OUT_HALF   = {5'b00001, {(S-1){1'b0}}};
   localparam logic [S+3:0]  OUT_MAXP   = {5'b00000, {(S-1){1'b1}}};
   localparam logic [S-1:0]  OUT_POS    = {1'b0, {(S-1){1'b1}}};
   localparam logic [S-1:0]  OUT_NEG    = {1'b1, {(S-1){1'b0}}};

   localparam logic [G:0] ATTACK_RAW  = spl_pkg::ATTACK_RESET[G:0];
   localparam logic [G:0] RELEASE_RAW = spl_pkg::RELEASE_RESET[G:0];
   localparam logic [G:0] ATTACK_RST  = (ATTACK_RAW > GAIN_ONE) ? GAIN_ONE : ATTACK_RAW;
   localparam logic [G:0] RELEASE_RST = (RELEASE_RAW > GAIN_ONE) ? GAIN_ONE : RELEASE_RAW;

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_MUL_L  = 4'd1;
   localparam logic [3:0] ST_MUL_R  = 4'd2;
   localparam logic [3:0] ST_PEAK   = 4'd3;
   localparam logic [3:0] ST_DIV    = 4'd4;
   localparam logic [3:0] ST_STEP   = 4'd5;
   localparam logic [3:0] ST_UPDATE = 4'd6;
   localparam logic [3:0] ST_OUT_L  = 4'd7;
   localparam logic [3:0] ST_OUT_R  = 4'd8;
   localparam logic [3:0] ST_EMIT   = 4'd9;

   logic [3:0]     state_ff;
   logic [3:0]     state_in;

   logic [S-2:0]   ceiling_ff;
   logic [G:0]     attack_ff;
   logic [G:0]     release_ff;
   logic [G:0]     gain_ff;

   logic [S-1:0]   mag_l_ff;
   logic [S-1:0]   mag_r_ff;
   logic           neg_l_ff;
   logic           neg_r_ff;
   logic [MGB-1:0] master_ff;
   logic           eob_ff;
   logic [S-1:0]   scaled_l_ff;
   logic [S-1:0]   scaled_r_ff;
   logic [G:0]     target_ff;
   logic           falling_ff;
   logic [PW-1:0]  prod_ff;
   logic [S-1:0]   out_l_ff;

   logic [S-1:0]   rsp_l_ff;
   logic [S-1:0]   rsp_r_ff;
   logic           rsp_last_ff;
   logic           rsp_valid_ff;

   logic [S-1:0]   req_left;
   logic [S-1:0]   req_right;
   logic           req_xfer;
   logic           cfg_write;
   logic [G:0]     wr_coef_raw;
   logic [G:0]     wr_coef;

   logic [AW-1:0]  mul_a;
   logic [BW-1:0]  mul_b;
   logic           mul_load;
   logic [PW-1:0]  sum_q16;
   logic [S-1:0]   scaled_rnd;
   logic [S-1:0]   peak;
   logic           over_ceiling;
   logic           falling;
   logic [G:0]     diff;
   logic [PW-1:0]  sum_step;
   logic [G:0]     step;
   logic [PW-1:0]  sum_out;
   logic [S+3:0]   out_mag;
   logic           out_neg;
   logic [S-1:0]   out_clip;
   logic           emit_ok;

   logic           div_start;
   logic           div_done;
   logic [G-1:0]   div_quot;

   assign req_left  = req_tdata[S-1:0];
   assign req_right = req_tdata[2*S-1:S];
   assign req_tready = (state_ff == ST_IDLE);
   assign req_xfer   = req_tvalid && req_tready;

   // Register port.
   assign csr_pready  = 1'b1;
   assign cfg_write   = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign wr_coef_raw = csr_pwdata[G:0];
   assign wr_coef     = (wr_coef_raw > GAIN_ONE) ? GAIN_ONE : wr_coef_raw;

   always_ff @(posedge clock) begin
      if (reset) begin
         ceiling_ff <= spl_pkg::CEILING_RESET[S-2:0];
         attack_ff  <= ATTACK_RST;
         release_ff <= RELEASE_RST;
      end else if (cfg_write) begin
         case (csr_paddr[3:2])
            spl_pkg::REG_CEILING: ceiling_ff <= csr_pwdata[S-2:0];
            spl_pkg::REG_ATTACK:  attack_ff  <= wr_coef;
            spl_pkg::REG_RELEASE: release_ff <= wr_coef;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         spl_pkg::REG_CEILING: csr_prdata = spl_pkg::CSR_DATA_BITS'(ceiling_ff);
         spl_pkg::REG_ATTACK:  csr_prdata = spl_pkg::CSR_DATA_BITS'(attack_ff);
         spl_pkg::REG_RELEASE: csr_prdata = spl_pkg::CSR_DATA_BITS'(release_ff);
         default:              csr_prdata = '0;
      endcase
   end

   // Shared multiplier operand selection.
   always_comb begin
      mul_load = 1'b1;
      case (state_ff)
         ST_MUL_L: begin
            mul_a = AW'(mag_l_ff);
            mul_b = BW'(master_ff);
         end
         ST_MUL_R: begin
            mul_a = AW'(mag_r_ff);
            mul_b = BW'(master_ff);
         end
         ST_STEP: begin
            mul_a = AW'(diff);
            mul_b = falling ? attack_ff : release_ff;
         end
         ST_OUT_L: begin
            mul_a = AW'(scaled_l_ff);
            mul_b = gain_ff;
         end
         ST_OUT_R: begin
            mul_a = AW'(scaled_r_ff);
            mul_b = gain_ff;
         end
         default: begin
            mul_a    = '0;
            mul_b    = '0;
            mul_load = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mul_load) begin
         prod_ff <= PW'(mul_a) * PW'(mul_b);
      end
   end

   assign sum_q16      = prod_ff + BIAS_Q16;
   assign scaled_rnd   = sum_q16[16 +: S];
   assign peak         = (scaled_rnd > scaled_l_ff) ? scaled_rnd : scaled_l_ff;
   assign over_ceiling = {peak, 3'b000} > (S+3)'(ceiling_ff);

   assign falling = target_ff < gain_ff;
   assign diff    = falling ? (gain_ff - target_ff) : (target_ff - gain_ff);

   assign sum_step = prod_ff + BIAS_STEP;
   assign step     = sum_step[G +: G+1];

   assign sum_out = prod_ff + BIAS_OUT;
   assign out_mag = sum_out[G-3 +: S+4];
   assign out_neg = (state_ff == ST_OUT_R) ? neg_l_ff : neg_r_ff;

   always_comb begin
      if (out_neg) begin
         out_clip = (out_mag >= OUT_HALF) ? OUT_NEG : (S'(0) - out_mag[S-1:0]);
      end else begin
         out_clip = (out_mag > OUT_MAXP) ? OUT_POS : out_mag[S-1:0];
      end
   end

   assign div_start = (state_ff == ST_PEAK) && over_ceiling;
   assign emit_ok   = !rsp_valid_ff || rsp_tready;

   spl_divider #(
      .SAMPLE_BITS        (SAMPLE_BITS),
      .GAIN_FRACTION_BITS (GAIN_FRACTION_BITS)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .numerator (ceiling_ff),
      .divisor   ({peak, 3'b000}),
      .done      (div_done),
      .quotient  (div_quot)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_xfer) state_in = ST_MUL_L;
         ST_MUL_L:  state_in = ST_MUL_R;
         ST_MUL_R:  state_in = ST_PEAK;
         ST_PEAK:   state_in = over_ceiling ? ST_DIV : ST_STEP;
         ST_DIV:    if (div_done) state_in = ST_STEP;
         ST_STEP:   state_in = ST_UPDATE;
         ST_UPDATE: state_in = ST_OUT_L;
         ST_OUT_L:  state_in = ST_OUT_R;
         ST_OUT_R:  state_in = ST_EMIT;
         ST_EMIT:   if (emit_ok) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         gain_ff      <= GAIN_ONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_UPDATE) begin
            gain_ff <= falling_ff ? (gain_ff - step) : (gain_ff + step);
         end
         if (state_ff == ST_EMIT && emit_ok) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         mag_l_ff  <= req_left[S-1] ? (~req_left + 1'b1) : req_left;
         mag_r_ff  <= req_right[S-1] ? (~req_right + 1'b1) : req_right;
         neg_l_ff  <= req_left[S-1];
         neg_r_ff  <= req_right[S-1];
         master_ff <= req_tdata[2*S +: MGB];
         eob_ff    <= req_tlast;
      end
      if (state_ff == ST_MUL_R) begin
         scaled_l_ff <= scaled_rnd;
      end
      if (state_ff == ST_PEAK) begin
         scaled_r_ff <= scaled_rnd;
         if (!over_ceiling) begin
            target_ff <= GAIN_ONE;
         end
      end
      if (state_ff == ST_DIV && div_done) begin
         target_ff <= {1'b0, div_quot};
      end
      if (state_ff == ST_STEP) begin
         falling_ff <= falling;
      end
      if (state_ff == ST_OUT_R) begin
         out_l_ff <= out_clip;
      end
      if (state_ff == ST_EMIT && emit_ok) begin
         rsp_l_ff    <= out_l_ff;
         rsp_r_ff    <= out_clip;
         rsp_last_ff <= eob_ff;
      end
   end

   assign rsp_tdata  = RSP_BITS'({rsp_r_ff, rsp_l_ff});
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;

   `SPL_ASSERT(a_gain_unity, clock, reset, gain_ff <= GAIN_ONE, "limiter gain above unity")
   `SPL_ASSERT(a_div_in_state, clock, reset, div_done |-> (state_ff == ST_DIV), "divider done outside divide state")
   `SPL_ASSERT(a_accept_starts, clock, reset, req_xfer |=> (state_ff == ST_MUL_L), "accepted frame did not start work")
   `SPL_ASSERT_NEVER(a_no_overwrite, clock, reset, rsp_valid_ff && !rsp_tready && (state_ff == ST_EMIT) && (state_in == ST_IDLE), "pending result overwritten")

endmodule

`default_nettype wire

// ----- bench/tb.sv -----
`timescale 1ns / 100ps
// Self-checking bench for stereo_peak_limiter: stream frames in, limited frames out, APB setup.
// Depends on spl_pkg and the RTL; expected frames come from a predictor kept in this file.

module tb;

   localparam int SB = spl_pkg::SAMPLE_BITS_DEFAULT;
   localparam int GF = spl_pkg::GAIN_FRACTION_BITS_DEFAULT;
   localparam int GAIN_W = spl_pkg::MASTER_GAIN_BITS;
   localparam int REQ_W = ((2*SB+GAIN_W+7)/8)*8;
   localparam int RSP_W = ((2*SB+7)/8)*8;
   localparam logic [1:0] REG_SPARE = 2'd3;
   localparam logic [63:0] GAIN_ONE = 64'd1 << GF;
   localparam logic [63:0] CEIL_MASK = (64'd1 << (SB-1)) - 64'd1;
   localparam logic [63:0] COEF_MASK = (64'd1 << (GF+1)) - 64'd1;
   localparam longint FULL_POS = (64'sd1 <<< (SB-1)) - 1;
   localparam longint FULL_NEG = -(64'sd1 <<< (SB-1));
   localparam int CYCLE_LIMIT = 500000;

   typedef struct {
      logic signed [SB-1:0] left;
      logic signed [SB-1:0] right;
      logic [GAIN_W-1:0] gain;
      logic eob;
   } frame_in_type;

   typedef struct {
      logic signed [SB-1:0] left;
      logic signed [SB-1:0] right;
      logic eob;
   } frame_out_type;

   logic clock = 1'b0;
   logic reset;
   logic [REQ_W-1:0] req_tdata;
   logic req_tvalid, req_tlast, req_tready;
   logic [RSP_W-1:0] rsp_tdata;
   logic rsp_tvalid, rsp_tlast, rsp_tready;
   logic csr_psel, csr_penable, csr_pwrite, csr_pready;
   logic [spl_pkg::CSR_ADDR_BITS-1:0] csr_paddr;
   logic [spl_pkg::CSR_DATA_BITS-1:0] csr_pwdata, csr_prdata;

   logic [63:0] ceil_reg, attack_reg, release_reg, lim_gain;
   frame_out_type limited_q[$];
   int errors = 0;
   int cycle_count = 0;
   bit steady = 1'b0;
   int hold = 0;

   stereo_peak_limiter dut (
      .clock(clock), .reset(reset),
      .req_tdata(req_tdata), .req_tvalid(req_tvalid), .req_tlast(req_tlast),
      .req_tready(req_tready),
      .rsp_tdata(rsp_tdata), .rsp_tvalid(rsp_tvalid), .rsp_tlast(rsp_tlast),
      .rsp_tready(rsp_tready),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic logic [63:0] magn(longint v);
      return (v < 0) ? -v : v;
   endfunction

   // Product of a signed sample and an unsigned gain, rounded half away from zero.
   function automatic longint scale_round(longint a, logic [63:0] b, int sh);
      logic [63:0] m;
      m = (magn(a) * b + (64'd1 << (sh - 1))) >> sh;
      return (a < 0) ? -longint'(m) : longint'(m);
   endfunction

   function automatic logic [63:0] coef_clamp(logic [63:0] v);
      v = v & COEF_MASK;
      return (v > GAIN_ONE) ? GAIN_ONE : v;
   endfunction

   function automatic logic signed [SB-1:0] clip_sample(longint v);
      if (v > FULL_POS) v = FULL_POS;
      if (v < FULL_NEG) v = FULL_NEG;
      return v[SB-1:0];
   endfunction

   function automatic frame_out_type limit_frame(frame_in_type f);
      longint l, r;
      logic [63:0] pk, target, coef, diff, step_sz;
      logic falling;
      frame_out_type o;
      l = scale_round(longint'(f.left), 64'(f.gain), 16);
      r = scale_round(longint'(f.right), 64'(f.gain), 16);
      pk = magn(l);
      if (magn(r) > pk) pk = magn(r);
      if ((pk << 3) > ceil_reg) target = (ceil_reg << GF) / (pk << 3);
      else target = GAIN_ONE;
      falling = target < lim_gain;
      coef = falling ? attack_reg : release_reg;
      diff = falling ? lim_gain - target : target - lim_gain;
      step_sz = (diff * coef + (GAIN_ONE - 64'd1)) >> GF;
      lim_gain = falling ? lim_gain - step_sz : lim_gain + step_sz;
      o.left = clip_sample(scale_round(l, lim_gain, GF - 3));
      o.right = clip_sample(scale_round(r, lim_gain, GF - 3));
      o.eob = f.eob;
      return o;
   endfunction

   function automatic frame_in_type make_frame(int l, int r, int g, bit e);
      frame_in_type f;
      f.left = l[SB-1:0];
      f.right = r[SB-1:0];
      f.gain = g[GAIN_W-1:0];
      f.eob = e;
      return f;
   endfunction

   task automatic csr_write(input logic [1:0] index, input logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {index, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (index)
         spl_pkg::REG_CEILING: ceil_reg = 64'(value) & CEIL_MASK;
         spl_pkg::REG_ATTACK:  attack_reg = coef_clamp(64'(value));
         spl_pkg::REG_RELEASE: release_reg = coef_clamp(64'(value));
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic send_frame(input frame_in_type f);
      int gap;
      gap = steady ? 0 : int'($urandom_range(0, 6));
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {{(REQ_W-2*SB-GAIN_W){1'b0}}, f.gain, f.right, f.left};
      req_tlast <= f.eob;
      do @(posedge clock); while (!req_tready);
      limited_q.push_back(limit_frame(f));
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (limited_q.size() != 0) @(posedge clock);
   endtask

   task automatic set_limits(input logic [31:0] ceil, input logic [31:0] atk,
                             input logic [31:0] rel);
      drain();
      csr_write(spl_pkg::REG_CEILING, ceil);
      csr_write(spl_pkg::REG_ATTACK, atk);
      csr_write(spl_pkg::REG_RELEASE, rel);
   endtask

   function automatic logic signed [SB-1:0] pick_sample(bit loud);
      int v;
      case ($urandom_range(0, 3))
         0: v = loud ? int'($urandom) : int'($urandom_range(0, 1 << 20));
         1: v = loud ? int'(FULL_POS) - int'($urandom_range(0, 255))
                     : int'($urandom_range(0, 15));
         2: v = loud ? int'($urandom_range(1 << 20, 32'(FULL_POS)))
                     : int'(ceil_reg >> 3) + int'($urandom_range(0, 8)) - 4;
         default: v = loud ? int'(FULL_NEG) + int'($urandom_range(0, 255))
                           : int'($urandom_range(0, 1 << 18));
      endcase
      if ($urandom_range(0, 1)) v = -v;
      return v[SB-1:0];
   endfunction

   // Loud and quiet bursts are picked at random so that the gain keeps attacking and releasing.
   task automatic run_random(input int count);
      int burst;
      bit loud;
      frame_in_type f;
      burst = 0;
      loud = 1'b0;
      for (int i = 0; i < count; i++) begin
         if (burst == 0) begin
            burst = int'($urandom_range(1, 24));
            loud = 1'($urandom_range(0, 1));
         end
         burst--;
         f.left = pick_sample(loud);
         f.right = pick_sample(loud);
         case ($urandom_range(0, 9))
            0: f.gain = '0;
            1: f.gain = '1;
            2, 3: f.gain = GAIN_W'($urandom_range(0, (1 << GAIN_W) - 1));
            default: f.gain = 17'd65536;
         endcase
         f.eob = ($urandom_range(0, 7) == 0);
         send_frame(f);
      end
   endtask

   task automatic test_directed();
      send_frame(make_frame(0, 0, 65536, 0));
      send_frame(make_frame(int'(FULL_POS), int'(FULL_NEG), 65536, 1));
      send_frame(make_frame(int'(FULL_NEG), int'(FULL_POS), 131071, 0));
      send_frame(make_frame(int'(FULL_POS), int'(FULL_POS), 0, 1));
      send_frame(make_frame(1017118, -1017118, 65536, 0));
      send_frame(make_frame(1017119, 0, 65536, 0));
      send_frame(make_frame(-1017119, 12, 65536, 0));
      send_frame(make_frame(1000, -3000000, 65536, 0));
      send_frame(make_frame(-1, 1, 65536, 1));
      send_frame(make_frame(24'hAAAAAA, 24'h555555, 17'h15555, 0));
      send_frame(make_frame(24'h555555, 24'hAAAAAA, 17'h0AAAA, 1));
      send_frame(make_frame(1 << 20, -(1 << 20), 32768, 0));
      for (int i = 0; i < 4; i++)
         send_frame(make_frame(int'($urandom_range(0, 1 << 16)), -300, 65536, 0));
   endtask

   // With a zero attack the gain never falls, so loud frames are clipped hard.
   task automatic test_clipping();
      set_limits(32'(CEIL_MASK), 32'd0, 32'(GAIN_ONE));
      send_frame(make_frame(0, 0, 65536, 0));
      send_frame(make_frame(1 << 20, -(1 << 20), 65536, 0));
      send_frame(make_frame(-(1 << 20), 1 << 20, 65536, 1));
      send_frame(make_frame(int'(FULL_POS), int'(FULL_NEG), 131071, 0));
      send_frame(make_frame((1 << 20) - 1, 1 - (1 << 20), 65536, 0));
      send_frame(make_frame(3 << 20, -(5 << 20), 65536, 1));
   endtask

   task automatic test_settings();
      set_limits(32'(spl_pkg::CEILING_RESET), 32'(spl_pkg::ATTACK_RESET),
                 32'(spl_pkg::RELEASE_RESET));
      run_random(150);
      set_limits(32'd0, 32'(GAIN_ONE), 32'(GAIN_ONE));
      run_random(80);
      set_limits(32'h00FF_FFFF, 32'hFFFF_FFFF, 32'd0);
      run_random(80);
      steady = 1'b1;
      set_limits(32'(CEIL_MASK), 32'd1, 32'd1);
      run_random(80);
      steady = 1'b0;
      for (int k = 0; k < 4; k++) begin
         set_limits($urandom,
                    $urandom_range(0, 1) ? $urandom : $urandom_range(0, 1 << GF),
                    $urandom_range(0, 1) ? $urandom : $urandom_range(0, 1 << GF));
         steady = (k == 2);
         run_random(100);
      end
      steady = 1'b0;
   endtask

   task automatic test_spare_address();
      drain();
      csr_write(REG_SPARE, $urandom);
      csr_write(REG_SPARE, 32'hFFFF_FFFF);
      run_random(60);
   endtask

   task automatic test_pause();
      set_limits(32'(spl_pkg::CEILING_RESET), 32'(spl_pkg::ATTACK_RESET),
                 32'(GAIN_ONE >> 6));
      run_random(40);
      drain();
      run_random(40);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         hold = int'($urandom_range(0, 6));
      end else if (!rsp_tready) begin
         if (hold == 0) rsp_tready <= 1'b1;
         else hold--;
      end else if (rsp_tvalid) begin
         hold = steady ? 0 : int'($urandom_range(0, 6));
         if (hold != 0) begin
            rsp_tready <= 1'b0;
            hold--;
         end
      end
   end

   always @(posedge clock) begin
      frame_out_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (limited_q.size() == 0) begin
            errors++;
            $display("%0t: result with none expected, actual %h last %b",
                     $time, rsp_tdata, rsp_tlast);
         end else begin
            want = limited_q.pop_front();
            if ($signed(rsp_tdata[SB-1:0]) !== want.left) begin
               errors++;
               $display("%0t: left_out expected %0d actual %0d", $time, want.left,
                        $signed(rsp_tdata[SB-1:0]));
            end
            if ($signed(rsp_tdata[2*SB-1:SB]) !== want.right) begin
               errors++;
               $display("%0t: right_out expected %0d actual %0d", $time, want.right,
                        $signed(rsp_tdata[2*SB-1:SB]));
            end
            if (rsp_tlast !== want.eob) begin
               errors++;
               $display("%0t: last_of_block expected %b actual %b", $time, want.eob,
                        rsp_tlast);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: errors");
         $finish;
      end
   end

   initial begin
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tlast <= 1'b0;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= '0;
      csr_pwdata <= '0;
      ceil_reg = spl_pkg::CEILING_RESET & CEIL_MASK;
      attack_reg = coef_clamp(spl_pkg::ATTACK_RESET);
      release_reg = coef_clamp(spl_pkg::RELEASE_RESET);
      lim_gain = GAIN_ONE;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_clipping();
      test_settings();
      test_spare_address();
      test_pause();
      drain();
      repeat (40) @(posedge clock);
      if (errors == 0) $display("tb: clean");
      else $display("tb: errors");
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+src
src/spl_pkg.sv
src/spl_divider.sv
src/stereo_peak_limiter.sv
bench/tb.sv
